// ----- sv/tcw_pkg.sv -----
// Shared constants, codes and result type for the text console writer.
// No dependencies; every other file but tcw_ram imports this package.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = COLOR_W + CHAR_W;
  localparam int RCOL_W   = 7;
  localparam int RROW_W   = 5;
  localparam int CURSOR_W = 11;
  localparam int WCOL_W   = 7;
  localparam int WROW_W   = 5;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE  = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE    = 8'h20;
  localparam logic [CELL_W-1:0]  BLANK_WORD    = 16'h0020;
  localparam logic [COLOR_W-1:0] DEF_COLOR_RST = 8'd14;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT       = 2'd0,
    OP_PUT_COLOR = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic [WCOL_W-1:0]   write_col;
    logic [WROW_W-1:0]   write_row;
    logic [CELL_W-1:0]   read_data;
  } res_t;

endpackage

// ----- sv/tcw_if.sv -----
// Channel interfaces: command input, result output and configuration write.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  cell_color;
  logic [RCOL_W-1:0]   cell_col;
  logic [RROW_W-1:0]   cell_row;

  modport source (output valid, opcode, char_code, cell_color, cell_col, cell_row,
                  input ready);
  modport sink   (input valid, opcode, char_code, cell_color, cell_col, cell_row,
                  output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_index;
  logic [WCOL_W-1:0]   write_col;
  logic [WROW_W-1:0]   write_row;
  logic [CELL_W-1:0]   read_data;

  modport source (output valid, cursor_index, write_col, write_row, read_data,
                  input ready);
  modport sink   (input valid, cursor_index, write_col, write_row, read_data,
                  output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/text_console_writer_unit.sv -----
// Text console writer top level: command sequencer around the screen RAM.
// Depends on tcw_pkg, tcw_if and tcw_ram.
`timescale 1ns / 1ps
//
//  channel   dir  beat payload                                          handshake
//  in_bus    in   opcode, char_code, cell_color, cell_col, cell_row     valid/ready
//  out_bus   out  cursor_index, write_col, write_row, read_data         valid/ready
//  cfg_bus   in   data (default_color)                                  valid/ready
//
//  A put at row ROWS scrolls first; copy and fill run one cell per cycle
//  through the single write port of the screen RAM.
//  After reset a clearing pass zeroes the RAM with in_bus.ready low;
//  configuration writes are taken throughout.
//  A two-entry output register lets the next command in while a result waits.

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_bus,
  tcw_out_if.source out_bus,
  tcw_cfg_if.sink   cfg_bus
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int AW     = $clog2(CELLS + 1);
  localparam int MAW    = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int CIW    = CW + 1;
  localparam int LW     = $clog2(ROWS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FILL   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_PUT    = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    FM_INIT   = 2'd0,
    FM_SCROLL = 2'd1,
    FM_CLEAR  = 2'd2
  } fill_mode_t;

  state_t             state_r, state_nxt;
  fill_mode_t         mode_r, mode_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [CELL_W-1:0]  fill_word_r, fill_word_nxt;
  logic               pend_r, pend_nxt;
  logic [MAW-1:0]     wa_r, wa_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [LW-1:0]      line_r, line_nxt;
  logic [AW-1:0]      cursor_r, cursor_nxt;
  logic [COLOR_W-1:0] def_color_r;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  res_t               out_r, out_nxt, skid_r, skid_nxt;
  logic               out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  logic               we, re;
  logic [MAW-1:0]     waddr, raddr;
  logic [CELL_W-1:0]  wdata, rdata;

  logic               in_rdy, accept, pop, push;
  op_t                op;
  logic               put_go;
  logic [CHAR_W-1:0]  put_ch;
  logic [COLOR_W-1:0] put_color;
  logic [AW-1:0]      put_addr, rd_addr, copy_src;
  logic [CIW-1:0]     col_inc;
  logic [LW-1:0]      line_inc;
  logic               wrap, rd_range;
  logic [CELL_W-1:0]  rd_val;
  res_t               res;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign op       = op_t'(in_bus.opcode);
  assign in_rdy   = (state_r == S_IDLE) && !skid_v_r;
  assign accept   = in_bus.valid && in_rdy;
  assign pop      = out_v_r && out_bus.ready;
  assign put_addr = AW'(line_r) * AW'(COLUMNS) + AW'(col_r);
  assign rd_addr  = AW'(in_bus.cell_row) * AW'(COLUMNS) + AW'(in_bus.cell_col);
  assign copy_src = cnt_r + AW'(COLUMNS);
  assign col_inc  = CIW'(col_r) + CIW'(1);
  assign line_inc = line_r + LW'(1);
  assign wrap     = col_inc >= CIW'(COLUMNS);
  assign rd_range = (int'(in_bus.cell_col) < COLUMNS) && (int'(in_bus.cell_row) < ROWS);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    fill_word_nxt = fill_word_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    cursor_nxt    = cursor_r;
    ch_nxt        = ch_r;
    color_nxt     = color_r;
    rd_ok_nxt     = rd_ok_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    push          = 1'b0;
    put_go        = 1'b0;
    put_ch        = in_bus.char_code;
    put_color     = (op == OP_PUT) ? def_color_r : in_bus.cell_color;
    rd_val        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUT, OP_PUT_COLOR: begin
              if (line_r >= LW'(ROWS)) begin
                ch_nxt    = in_bus.char_code;
                color_nxt = put_color;
                line_nxt  = LW'(ROWS - 1);
                cnt_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_SCROLL;
              end else begin
                put_go = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_nxt       = '0;
              fill_word_nxt = {def_color_r, SPACE_CODE};
              mode_nxt      = FM_CLEAR;
              state_nxt     = S_FILL;
            end
            OP_READ: begin
              re        = rd_range;
              raddr     = rd_addr[MAW-1:0];
              rd_ok_nxt = rd_range;
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCROLL: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata;
        end
        if (cnt_r < AW'(COPY_N)) begin
          re       = 1'b1;
          raddr    = copy_src[MAW-1:0];
          pend_nxt = 1'b1;
          wa_nxt   = cnt_r[MAW-1:0];
          cnt_nxt  = cnt_r + AW'(1);
        end else begin
          pend_nxt      = 1'b0;
          fill_word_nxt = BLANK_WORD;
          mode_nxt      = FM_SCROLL;
          state_nxt     = S_FILL;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = cnt_r[MAW-1:0];
        wdata = fill_word_r;
        if (cnt_r == AW'(CELLS - 1)) begin
          case (mode_r)
            FM_SCROLL: state_nxt = S_PUT;
            FM_CLEAR: begin
              cursor_nxt = '0;
              push       = 1'b1;
              state_nxt  = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_PUT: begin
        put_go    = 1'b1;
        put_ch    = ch_r;
        put_color = color_r;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        rd_val    = rd_ok_r ? rdata : '0;
        push      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (put_go) begin
      push = 1'b1;
      if (put_ch == NEWLINE_CODE) begin
        col_nxt  = '0;
        line_nxt = line_inc;
      end else begin
        we         = 1'b1;
        waddr      = put_addr[MAW-1:0];
        wdata      = {put_color, put_ch};
        col_nxt    = wrap ? '0 : col_inc[CW-1:0];
        line_nxt   = wrap ? line_inc : line_r;
        cursor_nxt = put_addr + AW'(1);
      end
    end

    res.cursor_index = CURSOR_W'(cursor_nxt);
    res.write_col    = WCOL_W'(col_nxt);
    res.write_row    = WROW_W'(line_nxt);
    res.read_data    = rd_val;
  end

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = res;
      end else begin
        out_nxt   = res;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      mode_r      <= FM_INIT;
      cnt_r       <= '0;
      fill_word_r <= '0;
      pend_r      <= 1'b0;
      col_r       <= '0;
      line_r      <= '0;
      cursor_r    <= '0;
      def_color_r <= DEF_COLOR_RST;
      out_v_r     <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      fill_word_r <= fill_word_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      cursor_r    <= cursor_nxt;
      out_v_r     <= out_v_nxt;
      skid_v_r    <= skid_v_nxt;
      if (cfg_bus.valid) begin
        def_color_r <= cfg_bus.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_r    <= wa_nxt;
    ch_r    <= ch_nxt;
    color_r <= color_nxt;
    rd_ok_r <= rd_ok_nxt;
    out_r   <= out_nxt;
    skid_r  <= skid_nxt;
  end

  assign in_bus.ready         = in_rdy;
  assign cfg_bus.ready        = 1'b1;
  assign out_bus.valid        = out_v_r;
  assign out_bus.cursor_index = out_r.cursor_index;
  assign out_bus.write_col    = out_r.write_col;
  assign out_bus.write_row    = out_r.write_row;
  assign out_bus.read_data    = out_r.read_data;

endmodule

// ----- sv/tcw_checker.sv -----
// Port-level assertions for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit.
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CURSOR_W-1:0] cursor_index,
  input logic [WCOL_W-1:0]   write_col,
  input logic [WROW_W-1:0]   write_row,
  input logic [CELL_W-1:0]   read_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_index) &&
      $stable(write_col) && $stable(write_row) && $stable(read_data))
    else $error("result beat changed while stalled");

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("command taken during post-reset screen clear");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(write_row) <= ROWS) && (int'(write_col) < COLUMNS))
    else $error("write position out of range");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(cursor_index) <= COLUMNS * ROWS)
    else $error("cursor past end of screen");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({cursor_index, write_col, write_row, read_data}))
    else $error("result beat carries unknown bits");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .cursor_index (out_bus.cursor_index),
  .write_col    (out_bus.write_col),
  .write_row    (out_bus.write_row),
  .read_data    (out_bus.read_data)
);

// ----- test/tb_top.sv -----
// Testbench for text_console_writer_unit: directed command table, then random text streams.
// Checks each beat against a table entry or a shadow screen and cursor; depends on tcw_pkg and tcw_if.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLS       = COLUMNS_DEF;
  localparam int LINES      = ROWS_DEF;
  localparam int CELLS      = COLS * LINES;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = CELLS + 100;
  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 180;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    op_t                op;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
    logic [RCOL_W-1:0]  col;
    logic [RROW_W-1:0]  row;
    bit                 typed;
    res_t               want;
  } script_row_t;

  localparam int SCRIPT_LEN = 22;

  script_row_t script [SCRIPT_LEN] = '{
    '{OP_READ,      8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_READ,      8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_PUT,       8'h41, 8'h00, 7'd0,   5'd0,  1'b1, '{11'd1,   7'd1, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{11'd1,   7'd1, 5'd0, 16'h0E41}},
    '{OP_PUT_COLOR, 8'hFF, 8'hFF, 7'd0,   5'd0,  1'b1, '{11'd2,   7'd2, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd1,   5'd0,  1'b1, '{11'd2,   7'd2, 5'd0, 16'hFFFF}},
    '{OP_PUT_COLOR, 8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{11'd3,   7'd3, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd2,   5'd0,  1'b1, '{11'd3,   7'd3, 5'd0, 16'h0000}},
    '{OP_PUT_COLOR, 8'h0A, 8'hAB, 7'd0,   5'd0,  1'b1, '{11'd3,   7'd0, 5'd1, 16'h0000}},
    '{OP_PUT,       8'h0A, 8'h00, 7'd0,   5'd0,  1'b1, '{11'd3,   7'd0, 5'd2, 16'h0000}},
    '{OP_PUT,       8'h7A, 8'hFF, 7'd127, 5'd31, 1'b1, '{11'd161, 7'd1, 5'd2, 16'h0000}},
    '{OP_CLEAR,     8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{11'd0,   7'd1, 5'd2, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{11'd0,   7'd1, 5'd2, 16'h0E20}},
    '{OP_READ,      8'h00, 8'h00, 7'd80,  5'd0,  1'b1, '{11'd0,   7'd1, 5'd2, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd0,   5'd25, 1'b1, '{11'd0,   7'd1, 5'd2, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd0,   5'd2,  1'b1, '{11'd0,   7'd1, 5'd2, 16'h0E20}},
    '{OP_PUT,       8'h0B, 8'h00, 7'd64,  5'd16, 1'b0, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_PUT_COLOR, 8'h09, 8'h55, 7'd0,   5'd0,  1'b0, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_PUT_COLOR, 8'h80, 8'h7F, 7'd0,   5'd0,  1'b0, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd1,   5'd2,  1'b0, '{11'd0,   7'd0, 5'd0, 16'h0000}},
    '{OP_READ,      8'h00, 8'h00, 7'd3,   5'd2,  1'b0, '{11'd0,   7'd0, 5'd0, 16'h0000}}
  };

  logic clk = 1'b0;
  logic rst_n;

  tcw_in_if  in_bus ();
  tcw_out_if out_bus ();
  tcw_cfg_if cfg_bus ();

  text_console_writer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CELL_W-1:0]  shadow_cells [CELLS];
  int unsigned        shadow_col;
  int unsigned        shadow_row;
  int unsigned        shadow_cursor;
  logic [COLOR_W-1:0] shadow_color;

  res_t status_q [$];
  int   fault_cnt;
  int   print_cnt;
  int   burst_left;
  int   gap_max;
  int   idle_cycles;
  int   drain_cyc;
  int   drain_mode;

  function automatic void put_glyph(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color);
    int i;
    if (shadow_row >= LINES) begin
      for (i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = BLANK_WORD;
      shadow_row = LINES - 1;
    end
    if (ch == NEWLINE_CODE) begin
      shadow_col = 0;
      shadow_row++;
      return;
    end
    shadow_cells[shadow_row * COLS + shadow_col] = {color, ch};
    shadow_col++;
    if (shadow_col >= COLS) begin
      shadow_col = 0;
      shadow_row++;
    end
    shadow_cursor = shadow_row * COLS + shadow_col;
  endfunction

  function automatic res_t console_step(op_t op, logic [CHAR_W-1:0] ch,
                                        logic [COLOR_W-1:0] color,
                                        logic [RCOL_W-1:0] col, logic [RROW_W-1:0] row);
    res_t r;
    int   i;
    r.read_data = '0;
    case (op)
      OP_PUT:       put_glyph(ch, shadow_color);
      OP_PUT_COLOR: put_glyph(ch, color);
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_color, SPACE_CODE};
        shadow_cursor = 0;
      end
      default: begin
        if (col < COLS && row < LINES) r.read_data = shadow_cells[row * COLS + col];
      end
    endcase
    r.cursor_index = CURSOR_W'(shadow_cursor);
    r.write_col    = WCOL_W'(shadow_col);
    r.write_row    = WROW_W'(shadow_row);
    return r;
  endfunction

  task automatic issue(op_t op, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
                       logic [RCOL_W-1:0] col, logic [RROW_W-1:0] row,
                       bit typed, res_t want);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.char_code  <= ch;
    in_bus.cell_color <= color;
    in_bus.cell_col   <= col;
    in_bus.cell_row   <= row;
    do @(posedge clk); while (!in_bus.ready);
    predicted = console_step(op, ch, color, col, row);
    status_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_color(logic [COLOR_W-1:0] value);
    in_bus.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow_color = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_read();
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      col = $urandom_range(127);
      row = $urandom_range(31);
    end else if (pick < 45) begin
      col = $urandom_range(COLS - 1);
      row = (shadow_row >= LINES) ? LINES - 1 : shadow_row;
    end else begin
      col = $urandom_range(COLS - 1);
      row = $urandom_range(LINES - 1);
    end
    issue(OP_READ, $urandom_range(255), $urandom_range(255), col, row, 1'b0, '0);
  endtask

  task automatic random_put(logic [CHAR_W-1:0] ch);
    op_t op;
    op = ($urandom_range(1) == 0) ? OP_PUT : OP_PUT_COLOR;
    issue(op, ch, $urandom_range(255), $urandom_range(127), $urandom_range(31), 1'b0, '0);
  endtask

  task automatic random_phase(int count);
    int sent;
    int pick;
    int len;
    int k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        issue(OP_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(127),
              $urandom_range(31), 1'b0, '0);
        sent++;
      end else if (pick < 30) begin
        len = $urandom_range(4, 1);
        for (k = 0; k < len; k++) random_read();
        sent += len;
      end else if (pick < 40) begin
        len = $urandom_range(8, 1);
        for (k = 0; k < len; k++) random_put(NEWLINE_CODE);
        sent += len;
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) len = $urandom_range(2);
        else if (pick < 80) len = $urandom_range(40, 4);
        else len = $urandom_range(85, 70);
        for (k = 0; k < len; k++) random_put($urandom_range(255));
        random_put(NEWLINE_CODE);
        sent += len + 1;
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fault_cnt++;
      if (print_cnt < MAX_PRINTS) begin
        print_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (status_q.size() == 0) begin
        fault_cnt++;
        if (print_cnt < MAX_PRINTS) begin
          print_cnt++;
          $display("%0t: result beat with nothing expected, expected none, got %h", $time,
                   {out_bus.cursor_index, out_bus.write_col, out_bus.write_row,
                    out_bus.read_data});
        end
      end else begin
        want = status_q.pop_front();
        check_field("cursor_index", want.cursor_index, out_bus.cursor_index);
        check_field("write_col", want.write_col, out_bus.write_col);
        check_field("write_row", want.write_row, out_bus.write_row);
        check_field("read_data", want.read_data, out_bus.read_data);
      end
    end
  end

  always @(negedge clk) begin
    drain_cyc++;
    if (drain_cyc % 300 == 0) drain_mode = $urandom_range(2);
    case (drain_mode)
      0:       out_bus.ready <= 1'b1;
      1:       out_bus.ready <= !((drain_cyc % 7) < 2 || (drain_cyc % 13) == 5);
      default: out_bus.ready <= $urandom_range(1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** text_console_writer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [COLOR_W-1:0] phase_color [PHASES];
    int i;
    phase_color = '{8'hFF, 8'h00, 8'h00, 8'h00, DEF_COLOR_RST, 8'h00};
    phase_color[2] = $urandom_range(255);
    phase_color[3] = $urandom_range(255);
    phase_color[5] = $urandom_range(255);
    for (i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    shadow_col = 0;
    shadow_row = 0;
    shadow_cursor = 0;
    shadow_color = DEF_COLOR_RST;
    fault_cnt = 0;
    print_cnt = 0;
    burst_left = 0;
    gap_max = 6;
    idle_cycles = 0;
    drain_cyc = 0;
    drain_mode = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_PUT;
    in_bus.char_code = '0;
    in_bus.cell_color = '0;
    in_bus.cell_col = '0;
    in_bus.cell_row = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < SCRIPT_LEN; i++) begin
      issue(script[i].op, script[i].ch, script[i].color, script[i].col, script[i].row,
            script[i].typed, script[i].want);
    end

    for (i = 0; i < PHASES; i++) begin
      write_color(phase_color[i]);
      gap_max = (i % 2 == 0) ? 6 : 2;
      random_phase(PHASE_CMDS);
    end

    in_bus.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (fault_cnt == 0) begin
      $display("** text_console_writer_unit: PASSED **");
    end else begin
      $display("** text_console_writer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_ram.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
test/tb_top.sv
